>>> design/pcc_pkg.sv
// Shared types, sizes and helpers for the pair co-clustering counter.
// Used by pcc_front, pcc_back and pair_coclustering_counter.
`timescale 1ns / 1ps

package pcc_pkg;

  // Store sizes
  localparam int unsigned MAX_ELEMENTS = 64;
  localparam int unsigned LABEL_BITS   = 8;
  localparam int unsigned COUNT_BITS   = 16;

  // Port field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned LABEL_W  = 8;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned CFG_W    = 7;

  // Derived widths
  localparam int unsigned IDX_W     = $clog2(MAX_ELEMENTS);
  localparam int unsigned POS_W     = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned CNT_DEPTH = MAX_ELEMENTS * MAX_ELEMENTS;
  localparam int unsigned CAD_W     = $clog2(CNT_DEPTH);

  localparam int unsigned ECOUNT_RESET = 64;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Command queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QA_W   = $clog2(QDEPTH);

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } pcc_action_e;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } pcc_op_e;

  typedef struct packed {
    pcc_op_e               op;
    logic [LABEL_BITS-1:0] label;
    logic [CAD_W-1:0]      addr;
    logic                  read_ok;
  } pcc_cmd_t;

  // Clamp the element count register into 2..MAX_ELEMENTS
  function automatic logic [POS_W-1:0] eff_count(logic [CFG_W-1:0] n);
    if (32'(n) < 32'd2) begin
      return POS_W'(2);
    end else if (32'(n) > 32'(MAX_ELEMENTS)) begin
      return POS_W'(MAX_ELEMENTS);
    end else begin
      return POS_W'(n);
    end
  endfunction

endpackage

>>> design/pcc_front.sv
// Front end of the pair co-clustering counter: accepts input items,
// decodes the action, forms the count address and queues commands.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_front
  import pcc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [LABEL_W-1:0]  label_i,
  input  logic [INDEX_W-1:0]  row_index_i,
  input  logic [INDEX_W-1:0]  col_index_i,
  input  logic                init_busy_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output pcc_cmd_t            cmd_o
);

  pcc_cmd_t        queue_q [QDEPTH];
  logic [QA_W-1:0] wptr_q, wptr_d;
  logic [QA_W-1:0] rptr_q, rptr_d;
  logic [QA_W:0]   fill_q, fill_d;

  pcc_cmd_t new_cmd;
  logic     keep;
  logic     wr_en;
  logic     rd_en;

  // Decode the action and form the pair address for reads
  always_comb begin
    new_cmd.label   = LABEL_BITS'(label_i);
    new_cmd.read_ok = (row_index_i < col_index_i) &&
                      (32'(col_index_i) < 32'(MAX_ELEMENTS));
    new_cmd.addr    = '0;
    if (new_cmd.read_ok) begin
      new_cmd.addr = CAD_W'(CAD_W'(row_index_i) * CAD_W'(MAX_ELEMENTS))
                   + CAD_W'(col_index_i);
    end
    new_cmd.op = OP_PUSH;
    keep       = 1'b1;
    unique case (pcc_action_e'(action_i))
      ACT_PUSH:  new_cmd.op = OP_PUSH;
      ACT_READ:  new_cmd.op = OP_READ;
      ACT_CLEAR: new_cmd.op = OP_CLEAR;
      ACT_NOP:   keep = 1'b0;
      default:   keep = 1'b0;
    endcase
  end

  // Queue handshakes; drop items that do nothing
  assign in_ready_o  = (fill_q != (QA_W+1)'(QDEPTH)) && !init_busy_i;
  assign wr_en       = in_valid_i && in_ready_o && keep;
  assign cmd_valid_o = (fill_q != '0);
  assign rd_en       = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = queue_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (wr_en) begin
      wptr_d = wptr_q + QA_W'(1);
    end
    if (rd_en) begin
      rptr_d = rptr_q + QA_W'(1);
    end
    if (wr_en && !rd_en) begin
      fill_d = fill_q + (QA_W+1)'(1);
    end else if (!wr_en && rd_en) begin
      fill_d = fill_q - (QA_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // Hold queue entries
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      queue_q[wptr_q] <= new_cmd;
    end
  end

endmodule

>>> design/pcc_back.sv
// Back end of the pair co-clustering counter: label store, count memory,
// push compare loop, pair reads, clear sweeps and the result register.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_back
  import pcc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_W-1:0]      cfg_element_count_i,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  pcc_cmd_t              cmd_i,
  output logic                  init_busy_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COUNT_BITS-1:0] pair_count_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PUSH  = 4'b0010,
    S_READ  = 4'b0100,
    S_CLEAR = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0]      ecount_q;
  logic [POS_W-1:0]      fill_q, fill_d;
  logic                  init_q, init_d;
  logic                  issue_q, issue_d;
  logic                  out_valid_q, out_valid_d;
  logic [CAD_W-1:0]      clr_q, clr_d;

  logic [IDX_W-1:0]      pos_q, pos_d;
  logic [IDX_W-1:0]      j_q, j_d;
  logic [LABEL_BITS-1:0] lab_q, lab_d;
  logic [CAD_W-1:0]      caddr_q, caddr_d;
  logic [CAD_W-1:0]      waddr_q, waddr_d;
  logic                  rok_q, rok_d;
  logic [COUNT_BITS-1:0] out_data_q, out_data_d;

  logic [LABEL_BITS-1:0] label_mem [MAX_ELEMENTS];
  logic [COUNT_BITS-1:0] count_mem [CNT_DEPTH];
  logic [LABEL_BITS-1:0] lab_rdata_q;
  logic [COUNT_BITS-1:0] cnt_rdata_q;

  logic                  lm_we;
  logic [IDX_W-1:0]      lm_waddr;
  logic                  cm_re;
  logic [CAD_W-1:0]      cm_raddr;
  logic                  cm_we;
  logic [CAD_W-1:0]      cm_waddr;
  logic [COUNT_BITS-1:0] cm_wdata;

  logic [POS_W-1:0]      eff;
  logic [POS_W-1:0]      p_sel;
  logic [POS_W-1:0]      p_next;

  assign eff    = eff_count(ecount_q);
  assign p_sel  = (fill_q >= eff) ? '0 : fill_q;
  assign p_next = p_sel + POS_W'(1);

  assign init_busy_o  = init_q;
  assign out_valid_o  = out_valid_q;
  assign pair_count_o = out_data_q;

  // Sequence pushes, reads and clears
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    init_d      = init_q;
    issue_d     = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    clr_d       = clr_q;
    pos_d       = pos_q;
    j_d         = j_q;
    lab_d       = lab_q;
    caddr_d     = caddr_q;
    waddr_d     = waddr_q;
    rok_d       = rok_q;
    out_data_d  = out_data_q;
    cmd_ready_o = 1'b0;
    lm_we       = 1'b0;
    lm_waddr    = p_sel[IDX_W-1:0];
    cm_re       = 1'b0;
    cm_raddr    = caddr_q;
    cm_we       = 1'b0;
    cm_waddr    = waddr_q;
    cm_wdata    = cnt_rdata_q + COUNT_BITS'(1);

    // Write back a matching pair, saturating
    if (issue_q && (lab_rdata_q == lab_q) && (cnt_rdata_q != COUNT_MAX)) begin
      cm_we = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        cmd_ready_o = (cmd_i.op != OP_READ) || !out_valid_q;
        if (cmd_valid_i && cmd_ready_o) begin
          unique case (cmd_i.op)
            OP_PUSH: begin
              lm_we   = 1'b1;
              fill_d  = (p_next >= eff) ? '0 : p_next;
              pos_d   = p_sel[IDX_W-1:0];
              j_d     = '0;
              lab_d   = cmd_i.label;
              caddr_d = CAD_W'(p_sel);
              if (p_sel != '0) begin
                state_d = S_PUSH;
              end
            end
            OP_READ: begin
              cm_re    = 1'b1;
              cm_raddr = cmd_i.addr;
              rok_d    = cmd_i.read_ok;
              state_d  = S_READ;
            end
            OP_CLEAR: begin
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_PUSH: begin
        // Issue one earlier position per cycle
        if (j_q != pos_q) begin
          cm_re    = 1'b1;
          cm_raddr = caddr_q;
          issue_d  = 1'b1;
          waddr_d  = caddr_q;
          j_d      = j_q + IDX_W'(1);
          caddr_d  = caddr_q + CAD_W'(MAX_ELEMENTS);
        end else if (!issue_q) begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        out_valid_d = 1'b1;
        out_data_d  = rok_q ? cnt_rdata_q : '0;
        state_d     = S_IDLE;
      end
      S_CLEAR: begin
        cm_we    = 1'b1;
        cm_waddr = clr_q;
        cm_wdata = '0;
        clr_d    = clr_q + CAD_W'(1);
        if (clr_q == CAD_W'(CNT_DEPTH - 1)) begin
          init_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers; reset starts a clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ecount_q    <= CFG_W'(ECOUNT_RESET);
      fill_q      <= '0;
      init_q      <= 1'b1;
      issue_q     <= 1'b0;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      init_q      <= init_d;
      issue_q     <= issue_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
      if (cfg_valid_i) begin
        ecount_q <= cfg_element_count_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    j_q        <= j_d;
    lab_q      <= lab_d;
    caddr_q    <= caddr_d;
    waddr_q    <= waddr_d;
    rok_q      <= rok_d;
    out_data_q <= out_data_d;
  end

  // Label store
  always_ff @(posedge clk_i) begin
    if (lm_we) begin
      label_mem[lm_waddr] <= cmd_i.label;
    end
    lab_rdata_q <= label_mem[j_q];
  end

  // Count memory
  always_ff @(posedge clk_i) begin
    if (cm_we) begin
      count_mem[cm_waddr] <= cm_wdata;
    end
    if (cm_re) begin
      cnt_rdata_q <= count_mem[cm_raddr];
    end
  end

endmodule

>>> design/pair_coclustering_counter.sv
// Pair co-clustering counter.
// Channels: input items (action, label, row_index, col_index) with
// in_valid_i/in_ready_o; results (pair_count) with out_valid_o/out_ready_i;
// element count register written over cfg_valid_i/cfg_ready_o, always ready.
// A push compares the new label with the p earlier labels of the sample,
// one position per cycle through the count memory read-modify-write port.
// A read passes through the command queue, the count memory read register
// and the result register, and holds the back end through S_READ.
// A clear sweeps all 4096 entries of the count memory, one entry per cycle.
// Action 3 is taken and dropped. A four-entry command queue sits between
// the decoder and the execution unit, so items are taken while a result
// waits. When the receiver stalls, the result register holds and reads
// behind it wait in the queue.
// Reset clears the fill position, sets the element count to 64 and runs a
// clearing sweep of all 4096 count memory entries; in_ready_o stays low
// through it, while configuration writes are still taken.
// Depends on pcc_pkg, pcc_front and pcc_back.
`timescale 1ns / 1ps

module pair_coclustering_counter
  import pcc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_W-1:0]      cfg_element_count_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ACTION_W-1:0]   action_i,
  input  logic [LABEL_W-1:0]    label_i,
  input  logic [INDEX_W-1:0]    row_index_i,
  input  logic [INDEX_W-1:0]    col_index_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COUNT_BITS-1:0] pair_count_o
);

  logic     cmd_valid;
  logic     cmd_ready;
  pcc_cmd_t cmd;
  logic     init_busy;

  assign cfg_ready_o = 1'b1;

  // Decode and queue items
  pcc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .label_i     (label_i),
    .row_index_i (row_index_i),
    .col_index_i (col_index_i),
    .init_busy_i (init_busy),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Execute commands against the stores
  pcc_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_element_count_i (cfg_element_count_i),
    .cmd_valid_i         (cmd_valid),
    .cmd_ready_o         (cmd_ready),
    .cmd_i               (cmd),
    .init_busy_o         (init_busy),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .pair_count_o        (pair_count_o)
  );

endmodule

>>> tb/sv/tb_pair_coclustering_counter.sv
// Self-checking testbench for pair_coclustering_counter: predicts pair counts
// from pushed labels, reads and clears, and checks every returned pair_count.
// Depends on pcc_pkg and the pair_coclustering_counter RTL.
`timescale 1ns / 1ps

module tb_pair_coclustering_counter;
  import pcc_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 5 * 4096 + 200;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned RAND_ITEMS    = 80;

  typedef struct {
    pcc_action_e         act;
    logic [LABEL_W-1:0]  lab;
    logic [INDEX_W-1:0]  row;
    logic [INDEX_W-1:0]  col;
    bit                  drain;
  } pcc_item_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_W-1:0]      cfg_element_count_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [ACTION_W-1:0]   action_i = '0;
  logic [LABEL_W-1:0]    label_i = '0;
  logic [INDEX_W-1:0]    row_index_i = '0;
  logic [INDEX_W-1:0]    col_index_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [COUNT_BITS-1:0] pair_count_o;

  // Pending transfers and expected pair counts
  pcc_item_t             item_q[$];
  logic [COUNT_BITS-1:0] pair_count_exp_q[$];
  int unsigned           reads_taken = 0;
  int unsigned           counts_returned = 0;
  int unsigned           errors = 0;
  int unsigned           cycle_cnt = 0;
  int unsigned           snd_idle_pct = 0;
  int unsigned           rcv_idle_pct = 0;

  // Shadow copy of the block state
  logic [CFG_W-1:0]      elem_count_reg = CFG_W'(ECOUNT_RESET);
  logic [LABEL_W-1:0]    label_mem[MAX_ELEMENTS];
  logic [COUNT_BITS-1:0] count_mem[MAX_ELEMENTS*MAX_ELEMENTS];
  int unsigned           fill_pos = 0;

  pair_coclustering_counter u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_element_count_i (cfg_element_count_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .action_i            (action_i),
    .label_i             (label_i),
    .row_index_i         (row_index_i),
    .col_index_i         (col_index_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .pair_count_o        (pair_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Clamp the element count into 2..MAX_ELEMENTS
  function automatic int unsigned samples_len();
    int unsigned n;
    n = elem_count_reg;
    if (n < 2) n = 2;
    if (n > MAX_ELEMENTS) n = MAX_ELEMENTS;
    return n;
  endfunction

  // Advance the shadow state by one accepted transfer
  function automatic void cocluster_apply(pcc_action_e act, logic [LABEL_W-1:0] lab,
                                          logic [INDEX_W-1:0] row, logic [INDEX_W-1:0] col);
    int unsigned n;
    int unsigned p;
    int unsigned a;
    n = samples_len();
    case (act)
      ACT_PUSH: begin
        p = (fill_pos >= n) ? 0 : fill_pos;
        label_mem[p] = lab;
        for (int unsigned j = 0; j < p; j++) begin
          a = j * MAX_ELEMENTS + p;
          if (label_mem[j] == lab && count_mem[a] != '1) count_mem[a] = count_mem[a] + 1'b1;
        end
        p++;
        fill_pos = (p >= n) ? 0 : p;
      end
      ACT_READ: begin
        if (row < col && col < MAX_ELEMENTS)
          pair_count_exp_q.push_back(count_mem[row * MAX_ELEMENTS + col]);
        else
          pair_count_exp_q.push_back('0);
      end
      ACT_CLEAR: begin
        foreach (count_mem[i]) count_mem[i] = '0;
      end
      default: ;
    endcase
  endfunction

  // Queue one transfer; fields the action ignores get random values
  task automatic queue_item(pcc_action_e act, int unsigned lab, int unsigned row,
                            int unsigned col, bit drain = 1'b0);
    pcc_item_t it;
    it.act   = act;
    it.lab   = (act == ACT_PUSH) ? LABEL_W'(lab) : LABEL_W'($urandom());
    it.row   = (act == ACT_READ) ? INDEX_W'(row) : INDEX_W'($urandom());
    it.col   = (act == ACT_READ) ? INDEX_W'(col) : INDEX_W'($urandom());
    it.drain = drain;
    item_q.push_back(it);
  endtask

  // Mostly label pushes over a small alphabet and reads inside the sample
  task automatic queue_random(int unsigned count);
    int unsigned n;
    int unsigned r;
    int unsigned c;
    bit          drain;
    n = samples_len();
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      drain = (k == 0) || ($urandom_range(0, 49) == 0);
      if (r < 58) begin
        if ($urandom_range(0, 3) != 0) queue_item(ACT_PUSH, $urandom_range(0, 3), 0, 0, drain);
        else queue_item(ACT_PUSH, $urandom(), 0, 0, drain);
      end else if (r < 94) begin
        if ($urandom_range(0, 3) != 0) begin
          c = $urandom_range(1, n - 1);
          queue_item(ACT_READ, 0, $urandom_range(0, c - 1), c, drain);
        end else begin
          queue_item(ACT_READ, 0, $urandom(), $urandom(), drain);
        end
      end else if (r < 98) begin
        queue_item(ACT_NOP, 0, 0, 0, drain);
      end else begin
        queue_item(ACT_CLEAR, 0, 0, 0, drain);
      end
    end
  endtask

  // Wait until every transfer is taken and every count returned, then let
  // any queued clear sweep finish
  task automatic wait_drained();
    do @(negedge clk_i);
    while (item_q.size() != 0 || in_valid_i || reads_taken != counts_returned);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_element_count(int unsigned value);
    @(posedge clk_i);
    cfg_valid_i         <= 1'b1;
    cfg_element_count_i <= CFG_W'(value);
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i    <= 1'b0;
    elem_count_reg = CFG_W'(value);
    @(negedge clk_i);
  endtask

  task automatic set_idle(int unsigned snd, int unsigned rcv);
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
  endtask

  // Driver: hold the payload until the transfer, then present the next item
  always @(posedge clk_i) begin : drive_items
    pcc_item_t nxt;
    if (rst_ni && !(in_valid_i && !in_ready_o)) begin
      if (item_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct &&
          !(item_q[0].drain && (reads_taken != counts_returned ||
            (in_valid_i && in_ready_o && action_i == ACT_READ)))) begin
        nxt = item_q.pop_front();
        in_valid_i  <= 1'b1;
        action_i    <= nxt.act;
        label_i     <= nxt.lab;
        row_index_i <= nxt.row;
        col_index_i <= nxt.col;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Monitor: check returned counts, then track the accepted input
  always @(posedge clk_i) begin : check_counts
    logic [COUNT_BITS-1:0] want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        counts_returned <= counts_returned + 1;
        if (pair_count_exp_q.size() == 0) begin
          $display("%0t: unexpected pair_count: expected none, actual %0d", $time, pair_count_o);
          errors++;
        end else begin
          want = pair_count_exp_q.pop_front();
          if (pair_count_o !== want) begin
            $display("%0t: pair_count mismatch: expected %0d, actual %0d",
                     $time, want, pair_count_o);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        cocluster_apply(pcc_action_e'(action_i), label_i, row_index_i, col_index_i);
        if (action_i == ACT_READ) reads_taken <= reads_taken + 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d counts still expected", $time, pair_count_exp_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    foreach (label_mem[i]) label_mem[i] = '0;
    foreach (count_mem[i]) count_mem[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: matching labels, pair reads off the upper triangle, clear
    set_idle(34, 55);
    write_element_count(4);
    queue_item(ACT_PUSH, 0, 0, 0);
    queue_item(ACT_PUSH, 255, 0, 0);
    queue_item(ACT_PUSH, 0, 0, 0);
    queue_item(ACT_PUSH, 255, 0, 0);
    queue_item(ACT_READ, 0, 0, 2);
    queue_item(ACT_READ, 0, 1, 3);
    queue_item(ACT_READ, 0, 0, 1);
    queue_item(ACT_READ, 0, 2, 2);
    queue_item(ACT_READ, 0, 3, 1);
    queue_item(ACT_READ, 0, 62, 63);
    queue_item(ACT_READ, 0, 63, 0);
    // Clear keeps the sample being filled
    queue_item(ACT_PUSH, 7, 0, 0);
    queue_item(ACT_CLEAR, 0, 0, 0);
    queue_item(ACT_PUSH, 7, 0, 0);
    queue_item(ACT_READ, 0, 0, 1);
    queue_item(ACT_READ, 0, 0, 2);
    queue_item(ACT_PUSH, 7, 0, 0);
    queue_item(ACT_NOP, 0, 0, 0);
    wait_drained();

    // Shrink the sample mid-fill: next push restarts at position 0,
    // counts past the new length stay readable
    write_element_count(2);
    queue_item(ACT_PUSH, 5, 0, 0);
    queue_item(ACT_PUSH, 5, 0, 0);
    queue_item(ACT_READ, 0, 0, 1);
    queue_item(ACT_READ, 0, 1, 2);
    queue_item(ACT_READ, 0, 0, 3);
    wait_drained();

    // Random phases over several sample lengths and idle patterns
    write_element_count(127);
    queue_random(RAND_ITEMS);
    wait_drained();
    write_element_count(0);
    queue_random(RAND_ITEMS);
    wait_drained();

    set_idle(55, 34);
    write_element_count(64);
    queue_random(RAND_ITEMS);
    wait_drained();
    write_element_count(1);
    queue_random(RAND_ITEMS);
    wait_drained();

    set_idle(0, 0);
    write_element_count(9);
    queue_random(RAND_ITEMS);
    wait_drained();
    write_element_count(40);
    queue_random(RAND_ITEMS);
    wait_drained();

    if (pair_count_exp_q.size() != 0) begin
      $display("%0t: %0d expected counts never returned", $time, pair_count_exp_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
